### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the ring buffer checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

### hw/rtl/arlr_pkg.sv
// ----------------------------------------------------------------------------
// arlr_pkg
// Widths, sizes and codes shared by the audio ring buffer files.
// ----------------------------------------------------------------------------
package arlr_pkg;

	// Ring and burst sizing.
	localparam int RING_DEPTH = 4096;
	localparam int MAX_BURST  = 64;
	localparam int AW         = $clog2(RING_DEPTH);
	localparam int PW         = AW + 1;
	localparam int HALF_DEPTH = RING_DEPTH / 2;

	// Field widths.
	localparam int POS_W    = 64;
	localparam int SAMPLE_W = 16;
	localparam int BURST_W  = 7;
	localparam int FRAME_W  = 16;

	// Latency target constants.
	localparam logic [FRAME_W-1:0] DEFAULT_FRAME = FRAME_W'(512);
	localparam int                 LEAD_FACTOR   = 2;

	// Configuration port.
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_MUTE           = 2'd0,
		REG_RUN_ENABLE     = 2'd1,
		REG_SOURCE_PRESENT = 2'd2,
		REG_FRAME_SIZE     = 2'd3
	} reg_idx_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} opcode_t;

endpackage

### hw/rtl/arlr_if.sv
// ----------------------------------------------------------------------------
// arlr_if
// Valid/ready channels for requests into and samples out of the ring buffer.
// ----------------------------------------------------------------------------

// Request channel: sample writes and read bursts.
interface arlr_cmd_if import arlr_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       opcode;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic        [BURST_W-1:0]  burst_len;

	modport source (output valid, output opcode, output sample_in, output burst_len,
		input ready);
	modport sink (input valid, input opcode, input sample_in, input burst_len,
		output ready);
endinterface

// Result channel: the samples of each read burst, the last one marked.
interface arlr_rsp_if import arlr_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       burst_last;

	modport source (output valid, output sample_out, output burst_last, input ready);
	modport sink (input valid, input sample_out, input burst_last, output ready);
endinterface

### hw/rtl/audio_ring_latency_resync.sv
// ----------------------------------------------------------------------------
// audio_ring_latency_resync: mono sample ring with latency resync.
// A write is taken while idle. A read burst holds the request side through
// CALC, PLAN1, PLAN2 and STREAM (straight to STREAM when silenced); samples follow
// one per cycle while the receiver takes them, through the single read port.
// Async reset clears positions, control and config registers; the ring stays unset.
// ----------------------------------------------------------------------------
module audio_ring_latency_resync import arlr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	arlr_cmd_if.sink             cmd,
	arlr_rsp_if.source           rsp,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CALC   = 5'b00010,
		ST_PLAN1  = 5'b00100,
		ST_PLAN2  = 5'b01000,
		ST_STREAM = 5'b10000
	} state_t;

	// Configuration registers.
	logic               mute_q;
	logic               run_enable_q;
	logic               source_present_q;
	logic [FRAME_W-1:0] frame_size_q;
	reg_idx_t           reg_idx;
	logic               cfg_wr;

	// Sequencer and positions.
	state_t             state_q;
	logic [POS_W-1:0]   w_q;
	logic [POS_W-1:0]   r_q;
	logic [BURST_W-1:0] n_q;
	logic [PW-1:0]      lead_q;
	logic [BURST_W-1:0] avail_q;
	logic [BURST_W-1:0] cnt_q;
	logic [AW-1:0]      addr_q;

	// Position compare results.
	logic [POS_W-1:0]   diff_q;
	logic               rgt_q;
	logic               rzero_q;
	logic               wgtl_q;
	logic               wgen_q;
	logic [PW-1:0]      d_q;

	// Read pipeline and output register.
	logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
	logic [SAMPLE_W-1:0] rdata_q;
	logic                valid_s1;
	logic                mem_s1;
	logic                last_s1;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic                last_q;

	// Combinational terms.
	logic                 accept;
	logic                 mem_we;
	logic                 silent;
	logic [BURST_W-1:0]   n_sat;
	logic [FRAME_W-1:0]   fs;
	logic [FRAME_W:0]     lead2;
	logic [FRAME_W:0]     lead_max;
	logic [FRAME_W:0]     lead_lim;
	logic [POS_W:0]       diff_full;
	logic                 w_hi;
	logic [PW-1:0]        w_lo;
	logic                 diff_over;
	logic [PW-1:0]        d_next;
	logic [PW-1:0]        n_pw;
	logic [PW-1:0]        dfin;
	logic [PW-1:0]        avail_pw;
	logic [PW-1:0]        rem;
	logic                 adv_s1;
	logic                 issue;
	logic                 rd_en;

	// Configuration port: writes land on the access cycle, reads are immediate.
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mute_q           <= 1'b0;
			run_enable_q     <= 1'b0;
			source_present_q <= 1'b0;
			frame_size_q     <= DEFAULT_FRAME;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_MUTE:           mute_q           <= pwdata[0];
				REG_RUN_ENABLE:     run_enable_q     <= pwdata[0];
				REG_SOURCE_PRESENT: source_present_q <= pwdata[0];
				REG_FRAME_SIZE:     frame_size_q     <= pwdata[FRAME_W-1:0];
				default:            mute_q           <= mute_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MUTE:           prdata = PDATA_W'(mute_q);
			REG_RUN_ENABLE:     prdata = PDATA_W'(run_enable_q);
			REG_SOURCE_PRESENT: prdata = PDATA_W'(source_present_q);
			REG_FRAME_SIZE:     prdata = PDATA_W'(frame_size_q);
			default:            prdata = '0;
		endcase
	end

	// Request acceptance and the latency target for a new burst.
	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign mem_we    = accept && (cmd.opcode == OP_WRITE);
	assign silent    = mute_q || !run_enable_q || !source_present_q;
	assign n_sat     = (cmd.burst_len > BURST_W'(MAX_BURST)) ? BURST_W'(MAX_BURST)
		: cmd.burst_len;
	assign fs        = (frame_size_q == '0) ? DEFAULT_FRAME : frame_size_q;
	assign lead2     = (FRAME_W+1)'(fs) * (FRAME_W+1)'(LEAD_FACTOR);
	assign lead_max  = (lead2 < (FRAME_W+1)'(n_sat)) ? (FRAME_W+1)'(n_sat) : lead2;
	assign lead_lim  = (lead_max > (FRAME_W+1)'(HALF_DEPTH)) ? (FRAME_W+1)'(HALF_DEPTH)
		: lead_max;

	// Writer-to-reader distance and narrow compares against the writer.
	assign diff_full = {1'b0, w_q} - {1'b0, r_q};
	assign w_hi      = |w_q[POS_W-1:AW];
	assign w_lo      = {1'b0, w_q[AW-1:0]};
	assign n_pw      = PW'(n_q);

	// Resync or overrun clamp, as a distance behind the writer.
	assign diff_over = (|diff_q[POS_W-1:PW]) || (diff_q[PW-1:0] > PW'(RING_DEPTH));

	always_comb begin
		if (rzero_q || rgt_q) begin
			d_next = wgtl_q ? lead_q : w_q[PW-1:0];
		end else if (diff_over) begin
			d_next = PW'(RING_DEPTH);
		end else begin
			d_next = diff_q[PW-1:0];
		end
	end

	// Backlog correction: jump, skip ahead, or keep the distance.
	always_comb begin
		if (d_q == '0) begin
			dfin     = '0;
			avail_pw = '0;
		end else if ((d_q < n_pw) && wgen_q) begin
			dfin     = n_pw;
			avail_pw = n_pw;
		end else if (d_q > n_pw) begin
			dfin     = (wgtl_q && (lead_q < d_q)) ? lead_q : d_q;
			avail_pw = (dfin > n_pw) ? n_pw : dfin;
		end else begin
			dfin     = d_q;
			avail_pw = d_q;
		end
		rem = dfin - avail_pw;
	end

	// Stream issue: one read slot per cycle while the next stage can move.
	assign adv_s1 = valid_s1 && (!out_valid_q || rsp.ready);
	assign issue  = (state_q == ST_STREAM) && (cnt_q < n_q) && (!valid_s1 || adv_s1);
	assign rd_en  = issue && (cnt_q < avail_q);

	// Sequencer and position registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			w_q     <= '0;
			r_q     <= '0;
			cnt_q   <= '0;
			avail_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (mem_we) begin
						w_q <= w_q + POS_W'(1);
					end else if (accept && (n_sat != '0)) begin
						cnt_q   <= '0;
						avail_q <= '0;
						state_q <= silent ? ST_STREAM : ST_CALC;
					end
				end
				ST_CALC: begin
					state_q <= ST_PLAN1;
				end
				ST_PLAN1: begin
					state_q <= ST_PLAN2;
				end
				ST_PLAN2: begin
					avail_q <= BURST_W'(avail_pw);
					r_q     <= w_q - POS_W'(rem);
					state_q <= ST_STREAM;
				end
				ST_STREAM: begin
					if (issue) begin
						cnt_q <= cnt_q + BURST_W'(1);
						if ((cnt_q + BURST_W'(1)) == n_q) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Burst parameters and per-step compare results.
	always_ff @(posedge clk) begin
		if (accept) begin
			n_q    <= n_sat;
			lead_q <= PW'(lead_lim);
		end
		if (state_q == ST_CALC) begin
			diff_q  <= diff_full[POS_W-1:0];
			rgt_q   <= diff_full[POS_W];
			rzero_q <= (r_q == '0);
			wgtl_q  <= w_hi || (w_lo > lead_q);
			wgen_q  <= w_hi || (w_lo >= n_pw);
		end
		if (state_q == ST_PLAN1) begin
			d_q <= d_next;
		end
		if (state_q == ST_PLAN2) begin
			addr_q <= w_q[AW-1:0] - dfin[AW-1:0];
		end else if (rd_en) begin
			addr_q <= addr_q + AW'(1);
		end
	end

	// Ring memory: writes only while idle, reads only while streaming.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[w_q[AW-1:0]] <= cmd.sample_in;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= ring_mem[addr_q];
		end
	end

	// Read stage: tracks the slot whose data the memory returns.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issue) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			mem_s1  <= (cnt_q < avail_q);
			last_s1 <= ((cnt_q + BURST_W'(1)) == n_q);
		end
	end

	// Output register: zero-fills slots past the available backlog.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			sample_q <= mem_s1 ? rdata_q : '0;
			last_q   <= last_s1;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.sample_out = sample_q;
	assign rsp.burst_last = last_q;

endmodule

### hw/rtl/arlr_checker.sv
// ----------------------------------------------------------------------------
// arlr_checker
// Port-level checks on the ring buffer's request and sample channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arlr_checker import arlr_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_valid,
	input logic                cmd_ready,
	input logic                cmd_opcode,
	input logic [BURST_W-1:0]  cmd_burst_len,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [SAMPLE_W-1:0] rsp_sample_out,
	input logic                rsp_burst_last
);

	logic wr_req;
	logic rd_req;

	assign wr_req = cmd_valid && cmd_ready && (cmd_opcode == OP_WRITE);
	assign rd_req = cmd_valid && cmd_ready && (cmd_opcode == OP_READ) && (cmd_burst_len != '0);

	// A stalled sample stays offered and unchanged.
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready, $stable(rsp_sample_out) && $stable(rsp_burst_last))

	// A read burst blocks further requests while it is planned or streamed.
	`ASSERT_NEXT(a_read_blocks, clk, arst_n, rd_req, !cmd_ready)

	// A sample write leaves the request side ready again.
	`ASSERT_NEXT(a_write_single, clk, arst_n, wr_req, cmd_ready)

endmodule

bind audio_ring_latency_resync arlr_checker u_arlr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.cmd_opcode     (cmd.opcode),
	.cmd_burst_len  (cmd.burst_len),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_sample_out (rsp.sample_out),
	.rsp_burst_last (rsp.burst_last)
);

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for audio_ring_latency_resync. Sample writes and read
// bursts go in over the request channel under several register settings and
// idle patterns. A local copy of the ring, both positions and the registers
// predicts every returned sample, which is checked in order as it arrives.
// ----------------------------------------------------------------------------
module testbench;
	import arlr_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 24;
	localparam int LONG_HOLD      = 300;

	typedef struct {
		opcode_t                    op;
		logic signed [SAMPLE_W-1:0] sample;
		logic        [BURST_W-1:0]  len;
	} ring_req_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} burst_sample_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	arlr_cmd_if cmd_ch();
	arlr_rsp_if rsp_ch();

	audio_ring_latency_resync dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Requests waiting to be offered, and samples the ring should return.
	ring_req_t     request_q[$];
	burst_sample_t expected_samples[$];

	// Local copy of the ring, its positions and its registers.
	logic [SAMPLE_W-1:0] ring_copy [RING_DEPTH];
	longint unsigned     write_pos;
	longint unsigned     read_pos;
	logic                mirror_mute;
	logic                mirror_run;
	logic                mirror_source;
	logic [FRAME_W-1:0]  mirror_frame;

	// Idle patterns and the long receiver hold.
	int send_idle_pct;
	int recv_stall_pct;
	int hold_request;
	int hold_left;

	bit cmd_taken;
	int error_count;
	int idle_cycles;

	// Coverage tallies for the summary.
	int writes_seen;
	int reads_seen;
	int silenced_reads;
	int samples_checked;
	int filled_samples;
	int rewind_reads;
	int skip_reads;
	int overrun_reads;

	// Clock, 2 ns period.
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Store one written sample in the local ring.
	function automatic void store_sample(input logic [SAMPLE_W-1:0] s);
		ring_copy[write_pos % RING_DEPTH] = s;
		write_pos++;
		writes_seen++;
	endfunction

	// Work out the samples of one read burst and advance the read position.
	function automatic void predict_burst(input logic [BURST_W-1:0] len);
		longint unsigned n;
		longint unsigned w;
		longint unsigned r;
		longint unsigned fs;
		longint unsigned lead;
		longint unsigned avail;
		longint unsigned want;
		longint unsigned copied;
		burst_sample_t   s;

		n = len;
		copied = 0;
		if (n == 0)
			return;
		if (n > MAX_BURST)
			n = MAX_BURST;
		reads_seen++;

		if (!mirror_mute && mirror_run && mirror_source) begin
			w = write_pos;
			r = read_pos;
			fs = mirror_frame;
			if (fs == 0)
				fs = DEFAULT_FRAME;
			lead = fs * LEAD_FACTOR;
			if (lead < n)
				lead = n;
			if (lead > HALF_DEPTH)
				lead = HALF_DEPTH;

			// Resync when no read position is held or it ran past the writer.
			if (r == 0 || r > w)
				r = (w > lead) ? w - lead : 0;
			// Overrun: the reader fell more than a whole ring behind.
			if (w - r > RING_DEPTH) begin
				r = w - RING_DEPTH;
				overrun_reads++;
			end
			avail = w - r;

			if (avail != 0) begin
				if (avail < n && w >= n) begin
					// Short backlog: step back to a full burst.
					r = w - n;
					avail = n;
					rewind_reads++;
				end else if (avail > n) begin
					// Long backlog: skip ahead to the latency target.
					want = (w > lead) ? w - lead : 0;
					if (want > r) begin
						r = want;
						avail = w - r;
						skip_reads++;
					end
					if (avail > n)
						avail = n;
				end
				copied = avail;
				for (longint unsigned k = 0; k < copied; k++) begin
					s.sample = ring_copy[(r + k) % RING_DEPTH];
					s.last = (k + 1 == n);
					expected_samples.push_back(s);
				end
				r += avail;
			end
			read_pos = r;
		end else begin
			silenced_reads++;
		end

		// Whatever the ring could not supply is filled with zeros.
		for (longint unsigned k = copied; k < n; k++) begin
			s.sample = '0;
			s.last = (k + 1 == n);
			expected_samples.push_back(s);
			filled_samples++;
		end
	endfunction

	function automatic void push_write(input logic signed [SAMPLE_W-1:0] s);
		ring_req_t req;

		req.op = OP_WRITE;
		req.sample = s;
		req.len = BURST_W'($urandom);
		request_q.push_back(req);
	endfunction

	function automatic void push_read(input logic [BURST_W-1:0] n);
		ring_req_t req;

		req.op = OP_READ;
		req.sample = SAMPLE_W'($urandom);
		req.len = n;
		request_q.push_back(req);
	endfunction

	// Mostly writes and ordinary bursts, with a few empty and oversized reads.
	function automatic void push_random(input int count);
		int                         pick;
		logic signed [SAMPLE_W-1:0] s;

		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				case ($urandom_range(9))
					0: s = 16'sh8000;
					1: s = 16'sh7FFF;
					2: s = '0;
					default: s = SAMPLE_W'($urandom);
				endcase
				push_write(s);
			end else if (pick < 88) begin
				push_read(BURST_W'($urandom_range(16, 1)));
			end else if (pick < 95) begin
				push_read(BURST_W'($urandom_range(MAX_BURST, 17)));
			end else if (pick < 97) begin
				push_read('0);
			end else begin
				push_read(BURST_W'($urandom_range(127, MAX_BURST + 1)));
			end
		end
	endfunction

	// Configuration write: setup cycle, then access cycle until pready.
	task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * int'(idx));
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MUTE:           mirror_mute = value[0];
			REG_RUN_ENABLE:     mirror_run = value[0];
			REG_SOURCE_PRESENT: mirror_source = value[0];
			REG_FRAME_SIZE:     mirror_frame = value[FRAME_W-1:0];
			default:            ;
		endcase
	endtask

	task automatic start_phase(input int send_pct, input int recv_pct);
		@(posedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// Wait until every request is taken and every sample is back, then settle.
	task automatic wait_drained();
		while (request_q.size() != 0 || cmd_ch.valid || expected_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Request driver: holds each request until it is taken.
	always @(negedge clk) begin
		ring_req_t req;

		if (arst_n && (!cmd_ch.valid || cmd_taken)) begin
			if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req = request_q.pop_front();
				cmd_ch.valid <= 1'b1;
				cmd_ch.opcode <= req.op;
				cmd_ch.sample_in <= req.sample;
				cmd_ch.burst_len <= req.len;
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// Sample receiver: random stalls, plus a long hold when one is requested.
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: predict on each taken request, check each returned sample.
	always @(posedge clk) begin
		burst_sample_t want;

		if (arst_n) begin
			cmd_taken = cmd_ch.valid && cmd_ch.ready;
			if (cmd_taken) begin
				if (cmd_ch.opcode == OP_WRITE)
					store_sample(cmd_ch.sample_in);
				else
					predict_burst(cmd_ch.burst_len);
			end

			if (rsp_ch.valid && rsp_ch.ready) begin
				samples_checked++;
				if (expected_samples.size() == 0) begin
					$display("%0t: unexpected sample: expected none, actual sample %0d last %0b",
						$time, rsp_ch.sample_out, rsp_ch.burst_last);
					error_count++;
				end else begin
					want = expected_samples.pop_front();
					if (rsp_ch.sample_out !== want.sample) begin
						$display("%0t: sample_out mismatch: expected %0d, actual %0d",
							$time, want.sample, rsp_ch.sample_out);
						error_count++;
					end
					if (rsp_ch.burst_last !== want.last) begin
						$display("%0t: burst_last mismatch: expected %0b, actual %0b",
							$time, want.last, rsp_ch.burst_last);
						error_count++;
					end
				end
			end

			// Watchdog on cycles where nothing moves on any port.
			if (cmd_taken || (rsp_ch.valid && rsp_ch.ready) || (psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: nothing moved for %0d cycles, %0d samples still awaited",
					$time, WATCHDOG_LIMIT, expected_samples.size());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Stimulus sequence.
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = OP_WRITE;
		cmd_ch.sample_in = '0;
		cmd_ch.burst_len = '0;
		rsp_ch.ready = 1'b0;
		write_pos = 0;
		read_pos = 0;
		mirror_mute = 1'b0;
		mirror_run = 1'b0;
		mirror_source = 1'b0;
		mirror_frame = DEFAULT_FRAME;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 0;
		hold_left = 0;
		cmd_taken = 1'b0;
		error_count = 0;
		idle_cycles = 0;
		writes_seen = 0;
		reads_seen = 0;
		silenced_reads = 0;
		samples_checked = 0;
		filled_samples = 0;
		rewind_reads = 0;
		skip_reads = 0;
		overrun_reads = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Registers at reset values: the stream is stopped, so reads are silent.
		// Also the sample extremes and an empty read.
		start_phase(0, 0);
		push_read(BURST_W'(3));
		push_write(16'sh8000);
		push_write(16'sh7FFF);
		push_write('0);
		push_write(-16'sd1);
		push_read('0);
		wait_drained();

		// Stream on with the smallest frame size.
		write_reg(REG_FRAME_SIZE, 32'd1);
		write_reg(REG_RUN_ENABLE, 32'd1);
		write_reg(REG_SOURCE_PRESENT, 32'd1);
		write_reg(REG_MUTE, 32'd0);

		// First read resyncs with too few samples, so the tail is zero-filled.
		// Then an empty backlog, a short backlog, a long backlog, an empty
		// read and an oversized read.
		start_phase(0, 0);
		push_read(BURST_W'(8));
		push_read(BURST_W'(127));
		repeat (3) push_write(SAMPLE_W'($urandom));
		push_read(BURST_W'(5));
		repeat (6) push_write(SAMPLE_W'($urandom));
		push_read(BURST_W'(2));
		push_read('0);
		push_read(BURST_W'(65));
		wait_drained();

		// Random traffic under each idle pattern and several frame sizes.
		start_phase(0, 0);
		push_random(25);
		wait_drained();

		write_reg(REG_FRAME_SIZE, 32'd0);
		start_phase(82, 0);
		push_random(25);
		wait_drained();

		write_reg(REG_FRAME_SIZE, 32'd3);
		start_phase(0, 82);
		push_random(25);
		wait_drained();

		write_reg(REG_FRAME_SIZE, 32'd65535);
		start_phase(37, 37);
		push_random(25);
		wait_drained();

		// Each of the three silencing conditions on its own.
		write_reg(REG_FRAME_SIZE, 32'd4);
		write_reg(REG_MUTE, 32'd1);
		start_phase(37, 37);
		push_random(10);
		wait_drained();

		write_reg(REG_MUTE, 32'd0);
		write_reg(REG_RUN_ENABLE, 32'd0);
		start_phase(82, 0);
		push_random(8);
		wait_drained();

		write_reg(REG_RUN_ENABLE, 32'd1);
		write_reg(REG_SOURCE_PRESENT, 32'd0);
		start_phase(0, 82);
		push_random(8);
		wait_drained();

		// Receiver holds off for a long stretch while long bursts keep coming.
		write_reg(REG_SOURCE_PRESENT, 32'd1);
		write_reg(REG_FRAME_SIZE, 32'd2);
		start_phase(0, 0);
		repeat (8) push_write(SAMPLE_W'($urandom));
		repeat (12) begin
			push_read(BURST_W'($urandom_range(MAX_BURST, 24)));
			push_write(SAMPLE_W'($urandom));
			push_write(SAMPLE_W'($urandom));
		end
		hold_request = LONG_HOLD;
		wait_drained();

		$display("Run covered %0d sample writes and %0d read bursts (%0d silenced), %0d samples.",
			writes_seen, reads_seen, silenced_reads, samples_checked);
		$display("Backlog handling: %0d rewinds, %0d skips, %0d overruns, %0d zero fills.",
			rewind_reads, skip_reads, overrun_reads, filled_samples);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
